FILE: src/csc_pkg.sv
// Shared constants, codes and the saturating adder for the sparse column store.
// Used by csc_sparse_matrix_store_core; depends on nothing.
package csc_pkg;

    localparam int MAX_DIM     = 256;
    localparam int MAX_ENTRIES = 1024;

    localparam int DIM_W  = $clog2(MAX_DIM);
    localparam int SIZE_W = $clog2(MAX_DIM + 1);
    localparam int ENT_W  = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int VAL_W  = 64;
    localparam int ROW_W  = 8;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;

    localparam int SIZE_REG_W = 9;
    localparam int CAP_REG_W  = 11;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 1;

    localparam int IN_BYTES_W  = ((CMD_W + 2 * ROW_W + VAL_W + 7) / 8) * 8;
    localparam int OUT_BYTES_W = ((VAL_W + 1 + STAT_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_GET = 2'd0,
        CMD_SET = 2'd1,
        CMD_ADD = 2'd2,
        CMD_RSV = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_SAT   = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MATRIX_SIZE    = 1'b0,
        CFG_ENTRY_CAPACITY = 1'b1
    } cfg_idx_t;

    // Returns {saturated, sum}
    function automatic logic [VAL_W:0] sat_add(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
        logic [VAL_W-1:0] s;
        logic             ovf;
        s   = a + b;
        ovf = (a[VAL_W-1] == b[VAL_W-1]) && (s[VAL_W-1] != a[VAL_W-1]);
        if (ovf) begin
            s = a[VAL_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end
        return {ovf, s};
    endfunction

endpackage

FILE: src/csc_sparse_matrix_store_core.sv
// Range errors go straight to the response; else the core reads the span,
// scans it, and on an insert shifts entries and bumps later column starts.
// Throughput: one transaction at a time; the scan, shift and column-start
// sweep share one entry memory port pair and one column-start port pair.
// Reset: synchronous active-low aresetn clears control, the entry count and
// the column-start valid bits; entry memories are not cleared.
module csc_sparse_matrix_store_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [csc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [csc_pkg::CFG_W-1:0]            cfg_wdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // command[1:0], row[9:2], column[17:10], operand_value[81:18], zero pad
    input  logic [csc_pkg::IN_BYTES_W-1:0]       s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // read_value[63:0], was_present[64], status[66:65], zero pad
    output logic [csc_pkg::OUT_BYTES_W-1:0]      m_tdata
);
    import csc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_END, S_SPAN, S_SCAN_RD, S_SCAN_CHK, S_ACT,
        S_SHIFT_RD, S_SHIFT_WR, S_COL_RD, S_COL_WR, S_OUT
    } state_t;

    state_t                 state_reg;
    logic [SIZE_REG_W-1:0]  size_reg;
    logic [CAP_REG_W-1:0]   cap_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CMD_W-1:0]       cmd_reg;
    logic [ROW_W-1:0]       row_reg;
    logic [DIM_W-1:0]       col_reg;
    logic [VAL_W-1:0]       opv_reg;
    logic [CNT_W-1:0]       start_reg;
    logic [CNT_W-1:0]       end_reg;
    logic [CNT_W-1:0]       idx_reg;
    logic [CNT_W-1:0]       slot_reg;
    logic [CNT_W-1:0]       k_reg;
    logic [DIM_W:0]         kc_reg;
    logic                   found_reg;
    logic [VAL_W-1:0]       old_reg;
    logic [VAL_W-1:0]       rv_reg;
    logic                   present_reg;
    logic [STAT_W-1:0]      status_reg;

    logic [CNT_W-1:0]       cs_mem [MAX_DIM];
    logic [MAX_DIM-1:0]     cs_valid_reg;
    logic [CNT_W-1:0]       cs_rdata_reg;
    logic                   cs_rvld_reg;
    logic [CNT_W-1:0]       cs_q;
    logic [DIM_W-1:0]       cs_raddr;
    logic                   cs_we;
    logic [DIM_W-1:0]       cs_waddr;

    logic [ROW_W-1:0]       row_mem [MAX_ENTRIES];
    logic [VAL_W-1:0]       val_mem [MAX_ENTRIES];
    logic [ROW_W-1:0]       row_q_reg;
    logic [VAL_W-1:0]       val_q_reg;
    logic [ENT_W-1:0]       ent_raddr;
    logic                   ent_we;
    logic [ENT_W-1:0]       ent_waddr;
    logic [ROW_W-1:0]       ent_wrow;
    logic [VAL_W-1:0]       ent_wval;

    logic [SIZE_W-1:0]      n_eff;
    logic [CNT_W-1:0]       cap_eff;
    logic [CNT_W-1:0]       end_raw;
    logic [CNT_W-1:0]       end_eff;
    logic [CNT_W-1:0]       k_dec;
    logic                   is_write;
    logic [VAL_W:0]         sum_sat;
    logic [VAL_W-1:0]       new_val;
    logic [CMD_W-1:0]       in_cmd;
    logic [ROW_W-1:0]       in_row;
    logic [DIM_W-1:0]       in_col;

    assign in_cmd = s_tdata[CMD_W-1:0];
    assign in_row = s_tdata[CMD_W +: ROW_W];
    assign in_col = s_tdata[CMD_W+ROW_W +: DIM_W];

    assign n_eff   = (size_reg > SIZE_REG_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM)
                                                       : SIZE_W'(size_reg);
    assign cap_eff = (cap_reg > CAP_REG_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                         : CNT_W'(cap_reg);
    assign cs_q    = cs_rvld_reg ? cs_rdata_reg : '0;
    assign end_raw = (&col_reg) ? count_reg : cs_q;
    assign end_eff = (end_raw > count_reg) ? count_reg : end_raw;
    assign k_dec   = k_reg - CNT_W'(1);
    assign is_write = (cmd_reg == CMD_SET) || ((cmd_reg == CMD_ADD) && (opv_reg != '0));
    assign sum_sat = sat_add(old_reg, opv_reg);
    assign new_val = ((cmd_reg == CMD_ADD) && found_reg) ? sum_sat[VAL_W-1:0] : opv_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {{(OUT_BYTES_W-VAL_W-1-STAT_W){1'b0}}, status_reg, present_reg, rv_reg};

    always_comb begin
        cs_raddr  = col_reg;
        cs_we     = 1'b0;
        cs_waddr  = kc_reg[DIM_W-1:0];
        ent_raddr = idx_reg[ENT_W-1:0];
        ent_we    = 1'b0;
        ent_waddr = slot_reg[ENT_W-1:0];
        ent_wrow  = row_reg;
        ent_wval  = new_val;
        unique case (state_reg)
            S_END:      cs_raddr = col_reg + DIM_W'(1);
            S_COL_RD:   cs_raddr = kc_reg[DIM_W-1:0];
            S_COL_WR:   cs_we    = 1'b1;
            S_SHIFT_RD: begin
                ent_raddr = k_dec[ENT_W-1:0];
                if (k_reg <= slot_reg) begin
                    ent_we   = 1'b1;
                    ent_wval = opv_reg;
                end
            end
            S_SHIFT_WR: begin
                ent_we    = 1'b1;
                ent_waddr = k_reg[ENT_W-1:0];
                ent_wrow  = row_q_reg;
                ent_wval  = val_q_reg;
            end
            S_ACT:      ent_we = is_write && found_reg;
            default:    ;
        endcase
    end

    always_ff @(posedge aclk) begin
        cs_rdata_reg <= cs_mem[cs_raddr];
        cs_rvld_reg  <= cs_valid_reg[cs_raddr];
        if (cs_we) begin
            cs_mem[cs_waddr] <= cs_q + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        row_q_reg <= row_mem[ent_raddr];
        val_q_reg <= val_mem[ent_raddr];
        if (ent_we) begin
            row_mem[ent_waddr] <= ent_wrow;
            val_mem[ent_waddr] <= ent_wval;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            size_reg     <= SIZE_REG_W'(MAX_DIM);
            cap_reg      <= CAP_REG_W'(MAX_ENTRIES);
            count_reg    <= '0;
            cs_valid_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_MATRIX_SIZE:    size_reg <= cfg_wdata[SIZE_REG_W-1:0];
                    CFG_ENTRY_CAPACITY: cap_reg  <= cfg_wdata[CAP_REG_W-1:0];
                endcase
            end
            if (cs_we) begin
                cs_valid_reg[cs_waddr] <= 1'b1;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg     <= in_cmd;
                        row_reg     <= in_row;
                        col_reg     <= in_col;
                        opv_reg     <= s_tdata[CMD_W+ROW_W+DIM_W +: VAL_W];
                        rv_reg      <= '0;
                        present_reg <= 1'b0;
                        found_reg   <= 1'b0;
                        if ((SIZE_W'(in_row) >= n_eff) || (SIZE_W'(in_col) >= n_eff)) begin
                            status_reg <= ST_RANGE;
                            state_reg  <= S_OUT;
                        end else begin
                            status_reg <= ST_OK;
                            state_reg  <= S_START;
                        end
                    end
                end
                S_START: state_reg <= S_END;
                S_END: begin
                    start_reg <= cs_q;
                    state_reg <= S_SPAN;
                end
                S_SPAN: begin
                    end_reg   <= end_eff;
                    idx_reg   <= start_reg;
                    state_reg <= S_SCAN_RD;
                end
                S_SCAN_RD: begin
                    if (idx_reg < end_reg) begin
                        state_reg <= S_SCAN_CHK;
                    end else begin
                        slot_reg  <= (end_reg < start_reg) ? start_reg : end_reg;
                        state_reg <= S_ACT;
                    end
                end
                S_SCAN_CHK: begin
                    if (row_q_reg == row_reg) begin
                        found_reg   <= 1'b1;
                        present_reg <= 1'b1;
                        old_reg     <= val_q_reg;
                        slot_reg    <= idx_reg;
                        state_reg   <= S_ACT;
                    end else if (row_q_reg > row_reg) begin
                        slot_reg  <= idx_reg;
                        state_reg <= S_ACT;
                    end else begin
                        idx_reg   <= idx_reg + CNT_W'(1);
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_ACT: begin
                    if (!is_write) begin
                        rv_reg    <= found_reg ? old_reg : '0;
                        state_reg <= S_OUT;
                    end else if (found_reg) begin
                        rv_reg     <= new_val;
                        status_reg <= (cmd_reg == CMD_ADD && sum_sat[VAL_W]) ? ST_SAT : ST_OK;
                        state_reg  <= S_OUT;
                    end else if ((count_reg >= cap_eff) || (slot_reg > count_reg)) begin
                        status_reg <= ST_FULL;
                        state_reg  <= S_OUT;
                    end else begin
                        rv_reg    <= opv_reg;
                        k_reg     <= count_reg;
                        state_reg <= S_SHIFT_RD;
                    end
                end
                S_SHIFT_RD: begin
                    if (k_reg > slot_reg) begin
                        state_reg <= S_SHIFT_WR;
                    end else begin
                        count_reg <= count_reg + CNT_W'(1);
                        kc_reg    <= {1'b0, col_reg} + (DIM_W+1)'(1);
                        state_reg <= S_COL_RD;
                    end
                end
                S_SHIFT_WR: begin
                    k_reg     <= k_dec;
                    state_reg <= S_SHIFT_RD;
                end
                S_COL_RD: begin
                    state_reg <= (kc_reg < (DIM_W+1)'(MAX_DIM)) ? S_COL_WR : S_OUT;
                end
                S_COL_WR: begin
                    kc_reg    <= kc_reg + (DIM_W+1)'(1);
                    state_reg <= S_COL_RD;
                end
                S_OUT: begin
                    if (m_tready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
